[sv/assert_macros.svh]
// Assertion macros shared by the projection unit RTL.
// ASSERT_CLK needs clk and rst_n, ASSERT_ALWAYS only clk, in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check, also live during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/wtsp_pkg.sv]
// Shared types and constants for the world-to-screen projection unit.
// No dependencies.
package wtsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int SIZE_W    = 14;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int CLIP_W    = SUM_W - FRAC_BITS;
  localparam int MAG_W     = CLIP_W + 1;
  localparam int DIV_W     = CLIP_W + 1;
  localparam int N_W       = SIZE_W + MAG_W + FRAC_BITS;
  localparam int QB        = WORD_W + 1;
  localparam int DIV_LAT   = QB + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W     = PTR_W + 1;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 64;

  // smallest clip w counted as visible: ceil(0.01 * 2^FRAC_BITS)
  localparam longint VIS_MIN = ((64'd1 << FRAC_BITS) + 64'd99) / 64'd100;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd1920;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd1080;

  localparam logic [CFG_IDX_W-1:0] REG_X_LO = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_HI = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HI = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_W_HI = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd7;

  localparam logic [WORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [QB-1:0]     POS_LIM = 33'h0_7FFF_FFFF;
  localparam logic [QB-1:0]     NEG_LIM = 33'h0_8000_0000;

  typedef struct packed {
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    logic signed [WORD_W-1:0] c;
    logic signed [WORD_W-1:0] t;
  } row_t;

  typedef struct packed {
    row_t x;
    row_t y;
    row_t w;
  } matrix_t;

  typedef struct packed {
    logic                     vis;
    logic signed [CLIP_W-1:0] cx;
    logic signed [CLIP_W-1:0] cy;
    logic signed [CLIP_W-1:0] w;
  } clip_t;

  typedef struct packed {
    logic vld;
    logic vis;
    logic neg_x;
    logic neg_y;
  } side_t;

endpackage

[sv/world_to_screen_projection_unit.sv]
// Throughput: one item per cycle while neither out_stall nor a full queue holds it.
// The 34-stage divider pipeline sets most of the depth.
// Front (3 stages) and back stall independently behind a 4-item queue.
// Reset (rst_n low, synchronous): matrix rows 0, width 1920, height 1080,
// all pipelines and the queue emptied.
// Top level: config registers, front end, queue, back end. Uses wtsp_pkg.
`include "assert_macros.svh"
module world_to_screen_projection_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wtsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wtsp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [wtsp_pkg::WORD_W-1:0] in_world_x,
  input  logic signed [wtsp_pkg::WORD_W-1:0] in_world_y,
  input  logic signed [wtsp_pkg::WORD_W-1:0] in_world_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_visible,
  output logic signed [wtsp_pkg::WORD_W-1:0] out_screen_x,
  output logic signed [wtsp_pkg::WORD_W-1:0] out_screen_y
);
  import wtsp_pkg::*;

  matrix_t            mat_r;
  logic [SIZE_W-1:0]  width_r, height_r;
  logic               q_push, q_pop, q_full, q_empty;
  clip_t              q_in, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r    <= '0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_X_LO: {mat_r.x.b, mat_r.x.a} <= cfg_data;
        REG_X_HI: {mat_r.x.t, mat_r.x.c} <= cfg_data;
        REG_Y_LO: {mat_r.y.b, mat_r.y.a} <= cfg_data;
        REG_Y_HI: {mat_r.y.t, mat_r.y.c} <= cfg_data;
        REG_W_LO: {mat_r.w.b, mat_r.w.a} <= cfg_data;
        REG_W_HI: {mat_r.w.t, mat_r.w.c} <= cfg_data;
        REG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  wtsp_front u_front (
    .clk(clk), .rst_n(rst_n), .mat(mat_r),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_world_x(in_world_x), .in_world_y(in_world_y), .in_world_z(in_world_z),
    .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  wtsp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wr_data(q_in), .pop(q_pop),
    .head(q_head), .full(q_full), .empty(q_empty)
  );

  wtsp_back u_back (
    .clk(clk), .rst_n(rst_n), .width(width_r), .height(height_r),
    .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_visible(out_visible),
    .out_screen_x(out_screen_x), .out_screen_y(out_screen_y)
  );

  `ASSERT_CLK(a_hidden_zero,
    out_valid && !out_visible |-> out_screen_x == 0 && out_screen_y == 0,
    "hidden point with nonzero coordinates")
  `ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid straight after reset")

endmodule

[sv/wtsp_front.sv]
// Front end: takes items, forms clip x, y, w dot products, flags visibility.
// Depends on wtsp_pkg.
module wtsp_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wtsp_pkg::matrix_t               mat,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [wtsp_pkg::WORD_W-1:0] in_world_x,
  input  logic signed [wtsp_pkg::WORD_W-1:0] in_world_y,
  input  logic signed [wtsp_pkg::WORD_W-1:0] in_world_z,
  input  logic                            q_full,
  output logic                            q_push,
  output wtsp_pkg::clip_t                 q_data
);
  import wtsp_pkg::*;

  logic en;
  logic v1_r, v2_r, v3_r;
  logic signed [PROD_W-1:0] p_r [0:8];
  logic signed [SUM_W-1:0]  sx_r, sy_r, sw_r;
  logic signed [CLIP_W-1:0] cx_r, cy_r, cw_r;
  row_t rows [0:2];

  assign rows[0] = mat.x;
  assign rows[1] = mat.y;
  assign rows[2] = mat.w;

  assign en       = !v3_r || !q_full;
  assign in_stall = !en;
  assign q_push   = v3_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        p_r[3*r]   <= in_world_x * rows[r].a;
        p_r[3*r+1] <= in_world_y * rows[r].b;
        p_r[3*r+2] <= in_world_z * rows[r].c;
      end
      sx_r <= SUM_W'(p_r[0]) + SUM_W'(p_r[1]) + SUM_W'(p_r[2]);
      sy_r <= SUM_W'(p_r[3]) + SUM_W'(p_r[4]) + SUM_W'(p_r[5]);
      sw_r <= SUM_W'(p_r[6]) + SUM_W'(p_r[7]) + SUM_W'(p_r[8]);
      cx_r <= CLIP_W'(sx_r >>> FRAC_BITS) + CLIP_W'(mat.x.t);
      cy_r <= CLIP_W'(sy_r >>> FRAC_BITS) + CLIP_W'(mat.y.t);
      cw_r <= CLIP_W'(sw_r >>> FRAC_BITS) + CLIP_W'(mat.w.t);
    end
  end

  always_comb begin
    q_data.cx  = cx_r;
    q_data.cy  = cy_r;
    q_data.w   = cw_r;
    q_data.vis = (cw_r >= $signed(CLIP_W'(VIS_MIN)));
  end

endmodule

[sv/wtsp_fifo.sv]
// Short queue between the front and back ends.
// Depends on wtsp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wtsp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wtsp_pkg::clip_t   wr_data,
  input  logic              pop,
  output wtsp_pkg::clip_t   head,
  output logic              full,
  output logic              empty
);
  import wtsp_pkg::*;

  clip_t             mem_r [0:FIFO_DEPTH-1];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full  = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  `ASSERT_CLK(a_no_overflow, push |-> !full, "push into full queue")
  `ASSERT_CLK(a_no_underflow, pop |-> !empty, "pop from empty queue")
  `ASSERT_CLK(a_cnt_track,
    1'b1 |=> cnt_r == $past(cnt_r) + CNT_W'($past(push)) - CNT_W'($past(pop)),
    "queue count drift")

endmodule

[sv/wtsp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on wtsp_pkg.
module wtsp_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [wtsp_pkg::N_W-1:0]     n,
  input  logic [wtsp_pkg::DIV_W-1:0]   d,
  output logic [wtsp_pkg::QB-1:0]      q,
  output logic                         big
);
  import wtsp_pkg::*;

  logic [DIV_W-1:0] r_r   [0:QB];
  logic [QB-1:0]    low_r [0:QB];
  logic [QB-1:0]    q_r   [0:QB];
  logic [DIV_W-1:0] d_r   [0:QB];
  logic             big_r [0:QB];
  logic [N_W-QB-1:0] n_hi;

  assign n_hi = n[N_W-1:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= DIV_W'(n_hi);
      low_r[0] <= n[QB-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= d;
      big_r[0] <= (N_W'(n_hi) >= N_W'(d));
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DIV_W:0] trial;
    logic           take;
    assign trial = {r_r[k-1], low_r[k-1][QB-1]};
    assign take  = (trial >= {1'b0, d_r[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]   <= take ? DIV_W'(trial - {1'b0, d_r[k-1]}) : DIV_W'(trial);
        low_r[k] <= {low_r[k-1][QB-2:0], 1'b0};
        q_r[k]   <= {q_r[k-1][QB-2:0], take};
        d_r[k]   <= d_r[k-1];
        big_r[k] <= big_r[k-1];
      end
    end
  end

  assign q   = q_r[QB];
  assign big = big_r[QB];

endmodule

[sv/wtsp_back.sv]
// Back end: scales by viewport size, divides by 2w, saturates, drives results.
// Depends on wtsp_pkg and wtsp_div.
module wtsp_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [wtsp_pkg::SIZE_W-1:0]     width,
  input  logic [wtsp_pkg::SIZE_W-1:0]     height,
  input  logic                            q_empty,
  input  wtsp_pkg::clip_t                 q_head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_visible,
  output logic signed [wtsp_pkg::WORD_W-1:0] out_screen_x,
  output logic signed [wtsp_pkg::WORD_W-1:0] out_screen_y
);
  import wtsp_pkg::*;

  localparam int PH_W = MAG_W - 32;

  logic en;
  side_t side_a_r, side_b_r, side_c_r;
  side_t side_d_r [0:DIV_LAT-1];
  logic signed [MAG_W-1:0] numx, numy;
  logic [MAG_W-1:0]  magx_r, magy_r;
  logic [DIV_W-1:0]  d_a_r, d_b_r, d_c_r;
  logic [SIZE_W+31:0]   plx_r, ply_r;
  logic [SIZE_W+PH_W-1:0] phx_r, phy_r;
  logic [N_W-1:0]    nx_r, ny_r;
  logic [QB-1:0]     qx, qy;
  logic              bigx, bigy;
  logic              out_valid_r, out_vis_r;
  logic [WORD_W-1:0] sx_r, sy_r;
  logic [WORD_W-1:0] sx_nxt, sy_nxt;

  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && !q_empty;

  assign numx = MAG_W'(q_head.cx) + MAG_W'(q_head.w);
  assign numy = MAG_W'(q_head.w) - MAG_W'(q_head.cy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_a_r <= '0;
      side_b_r <= '0;
      side_c_r <= '0;
      for (int i = 0; i < DIV_LAT; i++) side_d_r[i] <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      side_a_r.vld   <= !q_empty;
      side_a_r.vis   <= q_head.vis;
      side_a_r.neg_x <= numx[MAG_W-1];
      side_a_r.neg_y <= numy[MAG_W-1];
      side_b_r <= side_a_r;
      side_c_r <= side_b_r;
      side_d_r[0] <= side_c_r;
      for (int i = 1; i < DIV_LAT; i++) side_d_r[i] <= side_d_r[i-1];
      out_valid_r <= side_d_r[DIV_LAT-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      magx_r <= numx[MAG_W-1] ? MAG_W'(-numx) : MAG_W'(numx);
      magy_r <= numy[MAG_W-1] ? MAG_W'(-numy) : MAG_W'(numy);
      d_a_r  <= {q_head.w, 1'b0};
      plx_r  <= width * magx_r[31:0];
      phx_r  <= width * magx_r[MAG_W-1:32];
      ply_r  <= height * magy_r[31:0];
      phy_r  <= height * magy_r[MAG_W-1:32];
      d_b_r  <= d_a_r;
      nx_r   <= (N_W'({phx_r, 32'b0}) + N_W'(plx_r)) << FRAC_BITS;
      ny_r   <= (N_W'({phy_r, 32'b0}) + N_W'(ply_r)) << FRAC_BITS;
      d_c_r  <= d_b_r;
      out_vis_r <= side_d_r[DIV_LAT-1].vis;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
    end
  end

  wtsp_div u_div_x (.clk(clk), .en(en), .n(nx_r), .d(d_c_r), .q(qx), .big(bigx));
  wtsp_div u_div_y (.clk(clk), .en(en), .n(ny_r), .d(d_c_r), .q(qy), .big(bigy));

  function automatic logic [WORD_W-1:0] sat_word(input logic [QB-1:0] q, input logic big,
                                                 input logic neg);
    logic [QB-1:0] mag;
    if (neg) begin
      mag = (big || q > NEG_LIM) ? NEG_LIM : q;
      return WORD_W'(-mag);
    end
    return (big || q > POS_LIM) ? POS_MAX : q[WORD_W-1:0];
  endfunction

  always_comb begin
    sx_nxt = '0;
    sy_nxt = '0;
    if (side_d_r[DIV_LAT-1].vis) begin
      sx_nxt = sat_word(qx, bigx, side_d_r[DIV_LAT-1].neg_x);
      sy_nxt = sat_word(qy, bigy, side_d_r[DIV_LAT-1].neg_y);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_visible  = out_vis_r;
  assign out_screen_x = sx_r;
  assign out_screen_y = sy_r;

endmodule
